// ===== hw/rtl/pogu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pogu_pkg: shared types and constants of the polar occupancy grid update core
// Grid geometry, cell codes, op codes and the beat structures passed
// between the decoder, the column engine and the top level.
// ----------------------------------------------------------------------------
package pogu_pkg;

	// grid geometry
	localparam int ROWS         = 95;
	localparam int COLS         = 36;
	localparam int RANGE_STEP   = 30;
	localparam int ANGLE_STEP   = 10;
	localparam int FIRST_CENTER = 165;
	localparam int RANGE_LO     = FIRST_CENTER - (RANGE_STEP / 2);
	localparam int RANGE_HI     = RANGE_LO + ROWS * RANGE_STEP;

	// field widths
	localparam int RANGE_W = 12;
	localparam int ANGLE_W = 9;
	localparam int ROW_W   = 7;
	localparam int COL_W   = 6;
	localparam int CELL_W  = 2;

	// memory organization: one word per range row, every angle cell side by side
	localparam int ROW_AW = $clog2(ROWS);
	localparam int LINE_W = CELL_W * COLS;

	// reciprocal multiply for the bin divisions
	localparam int RECIP_SHIFT = 16;
	localparam int RANGE_RECIP = (2 ** RECIP_SHIFT + RANGE_STEP - 1) / RANGE_STEP;
	localparam int ANGLE_RECIP = (2 ** RECIP_SHIFT + ANGLE_STEP - 1) / ANGLE_STEP;
	localparam int PROD_W      = RANGE_W + RECIP_SHIFT;
	localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

	// cell codes
	localparam logic [CELL_W-1:0] CELL_FREE     = 2'd0;
	localparam logic [CELL_W-1:0] CELL_UNKNOWN  = 2'd1;
	localparam logic [CELL_W-1:0] CELL_OCCUPIED = 2'd2;

	// op codes
	localparam logic [1:0] OP_MEAS  = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	typedef struct packed {
		logic [1:0]         op;
		logic [RANGE_W-1:0] range_mm;
		logic [ANGLE_W-1:0] angle_deg;
		logic [ROW_W-1:0]   cell_row;
		logic [COL_W-1:0]   cell_col;
	} pogu_cmd_t;

	typedef struct packed {
		logic [CELL_W-1:0] occupancy;
		logic [ROW_W-1:0]  hit_row;
		logic [COL_W-1:0]  hit_col;
		logic              rejected;
	} pogu_res_t;

	typedef struct packed {
		logic             valid;
		logic             rejected;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} pogu_hit_t;

endpackage

// ===== hw/rtl/pogu_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pogu_decode: measurement to grid cell
// Two-stage pipeline: range bounds and world-angle wrap, then reciprocal
// multiplies that give the range row and the angle column.
// ----------------------------------------------------------------------------
module pogu_decode
	import pogu_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic [RANGE_W-1:0] range_mm,
	input  logic [ANGLE_W-1:0] angle_deg,
	input  logic [ANGLE_W-1:0] heading_deg,
	output pogu_hit_t          hit
);

	logic signed [11:0] w_raw;
	logic signed [11:0] w_wrap;
	logic [ANGLE_W-1:0] w_clamp;
	logic [RANGE_W-1:0] range_cap;
	logic [RANGE_W-1:0] x_next;
	logic               rej_next;

	logic               v_s1;
	logic               rej_s1;
	logic [RANGE_W-1:0] x_s1;
	logic [ANGLE_W-1:0] w_s1;

	logic               v_s2;
	logic               rej_s2;
	logic [PROD_W-1:0]  prod_r_s2;
	logic [PROD_W-1:0]  prod_c_s2;

	logic [QUOT_W-1:0]  quot_r;
	logic [QUOT_W-1:0]  quot_c;

	always_comb begin
		rej_next  = (range_mm < RANGE_W'(RANGE_LO)) || (range_mm > RANGE_W'(RANGE_HI));
		range_cap = (range_mm == RANGE_W'(RANGE_HI)) ? RANGE_W'(RANGE_HI - 1) : range_mm;
		x_next    = range_cap - RANGE_W'(RANGE_LO);

		w_raw = $signed({3'b000, heading_deg}) + 12'sd360 - $signed({3'b000, angle_deg});
		if (w_raw > 12'sd360) begin
			w_wrap = w_raw - 12'sd360;
		end else begin
			w_wrap = w_raw;
		end
		if (w_wrap < 12'sd0) begin
			w_clamp = '0;
		end else if (w_wrap > 12'sd359) begin
			w_clamp = ANGLE_W'(359);
		end else begin
			w_clamp = w_wrap[ANGLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= go;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rej_s1 <= rej_next;
			x_s1   <= x_next;
			w_s1   <= w_clamp;
		end
		if (v_s1) begin
			rej_s2    <= rej_s1;
			prod_r_s2 <= PROD_W'(x_s1) * PROD_W'(RANGE_RECIP);
			prod_c_s2 <= PROD_W'(w_s1) * PROD_W'(ANGLE_RECIP);
		end
	end

	assign quot_r = prod_r_s2[RECIP_SHIFT +: QUOT_W];
	assign quot_c = prod_c_s2[RECIP_SHIFT +: QUOT_W];

	assign hit.valid    = v_s2;
	assign hit.rejected = rej_s2;
	assign hit.row = (quot_r >= QUOT_W'(ROWS)) ? ROW_W'(ROWS - 1) : quot_r[ROW_W-1:0];
	assign hit.col = (quot_c >= QUOT_W'(COLS)) ? COL_W'(COLS - 1) : quot_c[COL_W-1:0];

endmodule

// ===== hw/rtl/pogu_column_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pogu_column_engine: grid store and its sequencer
// Row-wide memory with a registered read; sweeps a column read-modify-write,
// clears the store row by row, and serves single-cell reads.
// ----------------------------------------------------------------------------
module pogu_column_engine
	import pogu_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  pogu_cmd_t          in_cmd,
	input  logic [ANGLE_W-1:0] heading_deg,
	output logic               res_valid,
	input  logic               res_ready,
	output pogu_res_t          res
);

	localparam logic [2:0] ST_CLR  = 3'd0;
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_DEC  = 3'd2;
	localparam logic [2:0] ST_COL  = 3'd3;
	localparam logic [2:0] ST_RD   = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]        state_q;
	logic [ROW_AW-1:0] clr_row_q;
	logic              clr_reply_q;
	logic [ROW_AW-1:0] rd_row_q;
	logic              rd_more_q;
	logic [ROW_W-1:0]  hit_row_q;
	logic [COL_W-1:0]  hit_col_q;
	pogu_res_t         res_q;

	logic              v_s1;
	logic [ROW_AW-1:0] row_s1;

	logic [LINE_W-1:0] mem [ROWS];
	logic [LINE_W-1:0] rdata_q;

	logic              accept;
	logic              rd_in_range;
	logic              re;
	logic [ROW_AW-1:0] raddr;
	logic              we;
	logic [ROW_AW-1:0] waddr;
	logic [LINE_W-1:0] wdata;
	logic [LINE_W-1:0] line_mod;
	logic [CELL_W-1:0] cell_old;
	logic              near_hit;
	pogu_hit_t         hit;

	assign in_ready    = (state_q == ST_IDLE);
	assign accept      = in_valid && in_ready;
	assign rd_in_range = (in_cmd.cell_row < ROW_W'(ROWS)) && (in_cmd.cell_col < COL_W'(COLS));

	pogu_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (accept && (in_cmd.op == OP_MEAS)),
		.range_mm    (in_cmd.range_mm),
		.angle_deg   (in_cmd.angle_deg),
		.heading_deg (heading_deg),
		.hit         (hit)
	);

	// memory ports
	assign re    = (accept && (in_cmd.op == OP_READ) && rd_in_range)
	            || ((state_q == ST_COL) && rd_more_q);
	assign raddr = (state_q == ST_COL) ? rd_row_q : in_cmd.cell_row[ROW_AW-1:0];

	always_comb begin
		cell_old = rdata_q[{hit_col_q, 1'b0} +: CELL_W];
		near_hit = (ROW_W'(row_s1) == hit_row_q) || (ROW_W'(row_s1) == hit_row_q + ROW_W'(1));
		line_mod = rdata_q;
		if (near_hit || (cell_old == CELL_OCCUPIED)) begin
			line_mod[{hit_col_q, 1'b0} +: CELL_W] = CELL_OCCUPIED;
		end else begin
			line_mod[{hit_col_q, 1'b0} +: CELL_W] = CELL_UNKNOWN;
		end
	end

	assign we    = (state_q == ST_CLR) || ((state_q == ST_COL) && v_s1);
	assign waddr = (state_q == ST_CLR) ? clr_row_q : row_s1;
	assign wdata = (state_q == ST_CLR) ? '0 : line_mod;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_row_q   <= '0;
			clr_reply_q <= 1'b0;
			rd_more_q   <= 1'b0;
			v_s1        <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_COL) && rd_more_q;
			unique case (state_q)
				ST_CLR: begin
					if (clr_row_q == ROW_AW'(ROWS - 1)) begin
						state_q <= clr_reply_q ? ST_DONE : ST_IDLE;
					end else begin
						clr_row_q <= clr_row_q + ROW_AW'(1);
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						priority case (in_cmd.op)
							OP_MEAS: state_q <= ST_DEC;
							OP_CLEAR: begin
								clr_row_q   <= '0;
								clr_reply_q <= 1'b1;
								state_q     <= ST_CLR;
							end
							OP_READ: state_q <= rd_in_range ? ST_RD : ST_DONE;
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_DEC: begin
					if (hit.valid) begin
						if (hit.rejected) begin
							state_q <= ST_DONE;
						end else begin
							rd_more_q <= 1'b1;
							state_q   <= ST_COL;
						end
					end
				end
				ST_COL: begin
					if (rd_more_q && (rd_row_q == ROW_AW'(ROWS - 1))) begin
						rd_more_q <= 1'b0;
					end
					if (!rd_more_q && v_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_RD: state_q <= ST_DONE;
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload: result fields, sweep addresses
	always_ff @(posedge clk) begin
		row_s1 <= rd_row_q;
		if (accept) begin
			res_q     <= '0;
			hit_col_q <= in_cmd.cell_col;
		end
		if ((state_q == ST_DEC) && hit.valid) begin
			if (hit.rejected) begin
				res_q.rejected <= 1'b1;
			end else begin
				res_q.hit_row <= hit.row;
				res_q.hit_col <= hit.col;
				hit_row_q     <= hit.row;
				hit_col_q     <= hit.col;
				rd_row_q      <= hit.row[ROW_AW-1:0];
			end
		end
		if ((state_q == ST_COL) && rd_more_q && (rd_row_q != ROW_AW'(ROWS - 1))) begin
			rd_row_q <= rd_row_q + ROW_AW'(1);
		end
		if (state_q == ST_RD) begin
			res_q.occupancy <= rdata_q[{hit_col_q, 1'b0} +: CELL_W];
		end
	end

	assign res_valid = (state_q == ST_DONE);
	assign res       = res_q;

`ifndef SYNTH
	a_no_same_row_rw: assert property (@(posedge clk) disable iff (!arst_n)
		we && re |-> waddr != raddr)
		else $error("read and write hit the same row in one cycle");

	a_dec_only_when_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		hit.valid |-> state_q == ST_DEC)
		else $error("decode result arrived outside the decode wait");

	a_sweep_behind_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COL) && v_s1 |-> ROW_W'(row_s1) >= hit_row_q)
		else $error("column sweep wrote a row in front of the hit");
`endif

endmodule

// ===== hw/rtl/polar_occupancy_grid_update_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar_occupancy_grid_update_core: polar occupancy grid with stream ports
// Heading register, item intake, column engine and a registered result beat.
// ----------------------------------------------------------------------------
// The grid (95 range rows of 30 mm from 150 mm, by 36 angle columns of 10
// degrees) lives in one memory with one word per range row, so a measurement
// updates its column by reading, modifying and writing one row per cycle.
// Per item: a measurement sweeps its column from the hit row to the last
// row through the memory; a rejected measurement skips the sweep; a read
// goes to the memory only when the cell lies inside the grid; the unused
// op returns a zero result; a clear writes one row per cycle. After reset
// the memory is cleared in a pass during which s_tready stays low; cfg
// writes are taken at any time. One item is in work at a time, but the
// next item is taken while the previous result still waits on the master
// side. Write heading_deg only while no item is in work.
// ----------------------------------------------------------------------------
module polar_occupancy_grid_update_core
	import pogu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration: heading_deg
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [8:0]  cfg_data,
	// item beats
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // range_mm[11:0], angle_deg[20:12], cell_row[27:21],
	                               // cell_col[33:28], zero fill[39:34]
	input  logic [1:0]  s_tuser,   // op
	// result beats
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // occupancy[1:0], hit_row[8:2], hit_col[14:9], zero[15]
	output logic        m_tuser    // rejected
);

	logic [ANGLE_W-1:0] heading_q;
	pogu_cmd_t          cmd;
	logic               res_valid;
	logic               res_ready;
	pogu_res_t          res;
	logic               m_tvalid_q;
	logic [15:0]        m_tdata_q;
	logic               m_tuser_q;

	// heading register; always ready for a write
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heading_q <= '0;
		end else if (cfg_valid) begin
			heading_q <= cfg_data;
		end
	end

	// unpack the item beat
	assign cmd.op        = s_tuser;
	assign cmd.range_mm  = s_tdata[11:0];
	assign cmd.angle_deg = s_tdata[20:12];
	assign cmd.cell_row  = s_tdata[27:21];
	assign cmd.cell_col  = s_tdata[33:28];

	pogu_column_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_cmd      (cmd),
		.heading_deg (heading_q),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	// output register: take a new result when empty or draining this cycle
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// hold the payload while the beat is stalled
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_tdata_q <= {1'b0, res.hit_col, res.hit_row, res.occupancy};
			m_tuser_q <= res.rejected;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

`ifndef SYNTH
	a_result_lands: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready |=> m_tvalid)
		else $error("finished result did not reach the master side");
`endif

endmodule
